// ===== rtl/core/tilt_and_corner_height_assert.svh =====
// ----------------------------------------------------------------------------
// Tilt and corner height assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TILT_AND_CORNER_HEIGHT_ASSERT_SVH
`define TILT_AND_CORNER_HEIGHT_ASSERT_SVH
`ifndef SYNTHESIS
`define TCH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tch assertion failed");
`define TCH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tch assertion failed");
`else
`define TCH_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCH_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/tch_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt and corner height package
// Datapath widths, CORDIC arctangent table and register indexes.
// ----------------------------------------------------------------------------
package tch_pkg;

  localparam int CW       = 34;  // CORDIC x, y and z width
  localparam int ISQ_BITS = 30;  // square root result bits
  localparam int QB       = 31;  // tangent quotient bits

  localparam logic signed [CW-1:0] DEG90_Q = 34'sd589824000;
  localparam logic signed [32:0]   TAN_CAP = 33'sd2147483648;

  // round(atan(2^-i) in degrees * 6553600)
  localparam logic signed [CW-1:0] ATAN_Q [0:31] = '{
    34'sd294912000, 34'sd174096719, 34'sd91987925, 34'sd46694507,
    34'sd23437865,  34'sd11730358,  34'sd5866610,  34'sd2933484,
    34'sd1466764,   34'sd733385,    34'sd366693,   34'sd183346,
    34'sd91673,     34'sd45837,     34'sd22918,    34'sd11459,
    34'sd5730,      34'sd2865,      34'sd1432,     34'sd716,
    34'sd358,       34'sd179,       34'sd90,       34'sd45,
    34'sd22,        34'sd11,        34'sd6,        34'sd3,
    34'sd1,         34'sd1,         34'sd0,        34'sd0
  };

  localparam logic [2:0] REG_WHEELBASE = 3'd0;
  localparam logic [2:0] REG_TRACK     = 3'd1;
  localparam logic [2:0] REG_OFFSET_X  = 3'd2;
  localparam logic [2:0] REG_OFFSET_Y  = 3'd3;
  localparam logic [2:0] REG_ZERO_P    = 3'd4;
  localparam logic [2:0] REG_ZERO_R    = 3'd5;

  localparam logic [13:0]        RST_WHEELBASE = 14'd2200;
  localparam logic [13:0]        RST_TRACK     = 14'd1600;
  localparam logic signed [13:0] RST_OFFSET_X  = 14'sd180;
  localparam logic signed [13:0] RST_OFFSET_Y  = -14'sd120;

endpackage

// ===== rtl/core/tch_cordic.sv =====
// ----------------------------------------------------------------------------
// Tilt and corner height CORDIC pipeline
// Vectoring or rotation CORDIC: input stage, then one iteration per stage.
// ----------------------------------------------------------------------------
module tch_cordic import tch_pkg::*; #(
  parameter int STEPS  = 16,
  parameter bit VECTOR = 1'b1,
  parameter int SW     = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vin,
  input  logic [SW-1:0]        side_in,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  output logic                 vout,
  output logic [SW-1:0]        side_out,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [CW-1:0] z_out
);

  logic signed [CW-1:0] xs [0:STEPS];
  logic signed [CW-1:0] ys [0:STEPS];
  logic signed [CW-1:0] zs [0:STEPS];
  logic                 vs [0:STEPS];
  logic [SW-1:0]        ss [0:STEPS];

  // move a left-half vector into the right half first
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss[0] <= side_in;
      if (VECTOR && x_in < 0) begin
        if (y_in >= 0) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= DEG90_Q;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -DEG90_Q;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= z_in;
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    logic signed [CW-1:0] xsh;
    logic signed [CW-1:0] ysh;
    logic                 d;
    assign xsh = xs[k] >>> k;
    assign ysh = ys[k] >>> k;
    assign d   = VECTOR ? (ys[k] >= 0) : (zs[k] >= 0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (en) begin
        vs[k+1] <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ss[k+1] <= ss[k];
        if (VECTOR) begin
          xs[k+1] <= d ? xs[k] + ysh : xs[k] - ysh;
          ys[k+1] <= d ? ys[k] - xsh : ys[k] + xsh;
          zs[k+1] <= d ? zs[k] + ATAN_Q[k] : zs[k] - ATAN_Q[k];
        end else begin
          xs[k+1] <= d ? xs[k] - ysh : xs[k] + ysh;
          ys[k+1] <= d ? ys[k] + xsh : ys[k] - xsh;
          zs[k+1] <= d ? zs[k] - ATAN_Q[k] : zs[k] + ATAN_Q[k];
        end
      end
    end
  end

  assign vout     = vs[STEPS];
  assign side_out = ss[STEPS];
  assign x_out    = xs[STEPS];
  assign y_out    = ys[STEPS];
  assign z_out    = zs[STEPS];

endmodule

// ===== rtl/core/tch_isqrt.sv =====
// ----------------------------------------------------------------------------
// Tilt and corner height square root
// floor(sqrt((a + b) * 2^28)), one result bit per register stage.
// ----------------------------------------------------------------------------
module tch_isqrt import tch_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vin,
  input  logic [30:0]         sq_a,
  input  logic [30:0]         sq_b,
  input  logic [SW-1:0]       side_in,
  output logic                vout,
  output logic [ISQ_BITS-1:0] root,
  output logic [SW-1:0]       side_out
);

  localparam int NW = 2 * ISQ_BITS;

  logic [NW-1:0]       rem [1:ISQ_BITS];
  logic [ISQ_BITS-1:0] rt  [1:ISQ_BITS];
  logic                vs  [1:ISQ_BITS];
  logic [SW-1:0]       ss  [1:ISQ_BITS];
  logic [31:0]         sum;
  logic [NW-1:0]       n0;

  assign sum = 32'(sq_a) + 32'(sq_b);
  assign n0  = {sum, 28'b0};

  for (genvar k = 0; k < ISQ_BITS; k++) begin : g_bit
    localparam int B = ISQ_BITS - 1 - k;
    logic [NW-1:0]       r_i;
    logic [ISQ_BITS-1:0] q_i;
    logic                v_i;
    logic [SW-1:0]       s_i;
    logic [NW+1:0]       trial;
    logic                take;

    if (k == 0) begin : g_first
      assign r_i = n0;
      assign q_i = '0;
      assign v_i = vin;
      assign s_i = side_in;
    end else begin : g_next
      assign r_i = rem[k];
      assign q_i = rt[k];
      assign v_i = vs[k];
      assign s_i = ss[k];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ((NW+2)'(q_i) << (B + 1)) + ((NW+2)'(1) << (2 * B));
    assign take  = (NW+2)'(r_i) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (en) begin
        vs[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ss[k+1]  <= s_i;
        rem[k+1] <= take ? r_i - NW'(trial) : r_i;
        rt[k+1]  <= take ? (q_i | (ISQ_BITS'(1) << B)) : q_i;
      end
    end
  end

  assign vout     = vs[ISQ_BITS];
  assign root     = rt[ISQ_BITS];
  assign side_out = ss[ISQ_BITS];

endmodule

// ===== rtl/core/tch_div.sv =====
// ----------------------------------------------------------------------------
// Tilt and corner height tangent divider
// trunc(y * 2^16 / x) saturated to +-2^31, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tch_div import tch_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vin,
  input  logic signed [CW-1:0] num_y,
  input  logic signed [CW-1:0] den_x,
  input  logic [SW-1:0]        side_in,
  output logic                 vout,
  output logic signed [32:0]   quot,
  output logic [SW-1:0]        side_out
);

  localparam int MW = 48;
  localparam int TW = 64;

  logic [MW-1:0]   rem [0:QB];
  logic [QB-1:0]   q   [0:QB];
  logic [QB-1:0]   den [0:QB];
  logic            cap [0:QB];
  logic            neg [0:QB];
  logic            vs  [0:QB];
  logic [SW-1:0]   ss  [0:QB];

  logic [CW-1:0]   ya;
  logic [MW-1:0]   mag;
  logic            cap0;

  assign ya   = num_y < 0 ? CW'(-num_y) : CW'(num_y);
  assign mag  = {ya[31:0], 16'b0};
  // quotient of 2^31 or more, or a cosine that is not positive
  assign cap0 = (den_x <= 0) || (66'(mag) >= (66'(den_x) << 31));

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss[0]  <= side_in;
      rem[0] <= mag;
      q[0]   <= '0;
      den[0] <= den_x[QB-1:0];
      cap[0] <= cap0;
      neg[0] <= num_y < 0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int B = QB - 1 - k;
    logic [TW-1:0] trial;
    logic          take;
    assign trial = TW'(den[k]) << B;
    assign take  = TW'(rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (en) begin
        vs[k+1] <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ss[k+1]  <= ss[k];
        den[k+1] <= den[k];
        cap[k+1] <= cap[k];
        neg[k+1] <= neg[k];
        rem[k+1] <= take ? rem[k] - MW'(trial) : rem[k];
        q[k+1]   <= take ? (q[k] | (QB'(1) << B)) : q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vs[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= ss[QB];
      if (cap[QB]) begin
        quot <= neg[QB] ? -TAN_CAP : TAN_CAP;
      end else begin
        quot <= neg[QB] ? -(33'(q[QB])) : 33'(q[QB]);
      end
    end
  end

endmodule

// ===== rtl/core/tilt_and_corner_height.sv =====
// ----------------------------------------------------------------------------
// Tilt and corner height
// Pitch and roll from one accelerometer sample, projected to four corners.
// ----------------------------------------------------------------------------
// Input channel: accel_x/y/z, a transaction on in_valid && in_ready.
// Output channel: status, pitch_cdeg, roll_cdeg and the four corner heights,
// a transaction on out_valid && out_ready. One result per sample, in order.
// Throughput: one sample per cycle while the receiver does not stall. The pipeline
// holds the 30-stage square root, two CORDIC passes of CORDIC_STEPS + 1 stages
// each and the 33-stage tangent divider.
// The whole pipeline advances while the output register is empty or taken;
// when the receiver stalls every stage holds and in_ready drops.
// Reset empties the pipeline and loads the geometry registers with their
// defaults. Write registers through cfg_we/cfg_index/cfg_data only while no
// transaction is in flight; an out-of-range value loads the default.
// ----------------------------------------------------------------------------
`include "tilt_and_corner_height_assert.svh"

module tilt_and_corner_height import tch_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic signed [15:0] pitch_cdeg,
  output logic signed [15:0] roll_cdeg,
  output logic signed [21:0] front_left_height,
  output logic signed [21:0] front_right_height,
  output logic signed [21:0] rear_left_height,
  output logic signed [21:0] rear_right_height
);

  // configuration registers
  logic [13:0]        wheelbase;
  logic [13:0]        track;
  logic signed [13:0] offset_x;
  logic signed [13:0] offset_y;
  logic signed [14:0] zero_pitch;
  logic signed [14:0] zero_roll;
  logic [13:0]        wd_u;
  logic signed [13:0] wd_s14;
  logic signed [14:0] wd_s15;

  assign wd_u   = cfg_data[13:0];
  assign wd_s14 = cfg_data[13:0];
  assign wd_s15 = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase  <= RST_WHEELBASE;
      track      <= RST_TRACK;
      offset_x   <= RST_OFFSET_X;
      offset_y   <= RST_OFFSET_Y;
      zero_pitch <= '0;
      zero_roll  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHEELBASE: begin
          wheelbase <= (wd_u < 14'd100 || wd_u > 14'd10000) ? RST_WHEELBASE : wd_u;
        end
        REG_TRACK: begin
          track <= (wd_u < 14'd100 || wd_u > 14'd10000) ? RST_TRACK : wd_u;
        end
        REG_OFFSET_X: begin
          offset_x <= (wd_s14 < -14'sd5000 || wd_s14 > 14'sd5000) ? RST_OFFSET_X : wd_s14;
        end
        REG_OFFSET_Y: begin
          offset_y <= (wd_s14 < -14'sd5000 || wd_s14 > 14'sd5000) ? RST_OFFSET_Y : wd_s14;
        end
        REG_ZERO_P: begin
          zero_pitch <= (wd_s15 < -15'sd9000 || wd_s15 > 15'sd9000) ? '0 : wd_s15;
        end
        REG_ZERO_R: begin
          zero_roll <= (wd_s15 < -15'sd9000 || wd_s15 > 15'sd9000) ? '0 : wd_s15;
        end
        default: begin
        end
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---- stage A: input register
  logic               va;
  logic signed [15:0] ax_a, ay_a, az_a;
  logic               zero_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_a   <= accel_x;
      ay_a   <= accel_y;
      az_a   <= accel_z;
      zero_a <= accel_x == 16'sd0 && accel_y == 16'sd0 && accel_z == 16'sd0;
    end
  end

  // ---- stage B: squares
  logic               vb;
  logic signed [31:0] sqy_full, sqz_full;
  logic [30:0]        sqy_b, sqz_b;
  logic [48:0]        side_b;

  assign sqy_full = ay_a * ay_a;
  assign sqz_full = az_a * az_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqy_b  <= sqy_full[30:0];
      sqz_b  <= sqz_full[30:0];
      side_b <= {zero_a, ax_a, ay_a, az_a};
    end
  end

  // ---- square root of (y^2 + z^2) * 2^28
  logic                vi;
  logic [ISQ_BITS-1:0] root_i;
  logic [48:0]         side_i;
  logic                zero_i;
  logic signed [15:0]  ax_i, ay_i, az_i;

  tch_isqrt #(.SW(49)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (vb),
    .sq_a     (sqy_b),
    .sq_b     (sqz_b),
    .side_in  (side_b),
    .vout     (vi),
    .root     (root_i),
    .side_out (side_i)
  );

  assign {zero_i, ax_i, ay_i, az_i} = side_i;

  // ---- vectoring CORDIC for pitch and roll
  logic signed [CW-1:0] ax_s, ay_s, az_s;
  logic signed [CW-1:0] pv_x, pv_y, rv_x, rv_y;
  logic                 pc_v, rc_v;
  logic                 zero_c, rzero_c;
  logic signed [CW-1:0] pz_c, rz_c;

  assign ax_s = CW'(ax_i);
  assign ay_s = CW'(ay_i);
  assign az_s = CW'(az_i);
  assign pv_x = CW'(root_i);
  assign pv_y = -(ax_s <<< 14);
  assign rv_x = az_s <<< 14;
  assign rv_y = ay_s <<< 14;

  tch_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .SW(1)) u_pitch_vec (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (vi),
    .side_in  (zero_i),
    .x_in     (pv_x),
    .y_in     (pv_y),
    .z_in     ('0),
    .vout     (pc_v),
    .side_out (zero_c),
    .x_out    (),
    .y_out    (),
    .z_out    (pz_c)
  );

  tch_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .SW(1)) u_roll_vec (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (vi),
    .side_in  (ay_i == 16'sd0 && az_i == 16'sd0),
    .x_in     (rv_x),
    .y_in     (rv_y),
    .z_in     ('0),
    .vout     (rc_v),
    .side_out (rzero_c),
    .x_out    (),
    .y_out    (),
    .z_out    (rz_c)
  );

  // ---- stage D: round, clamp, zero offsets
  logic signed [CW-1:0] p_rnd, r_rnd, p_clp, r_clp;
  logic                 vd, zero_d;
  logic signed [15:0]   pitch_d, roll_d;

  always_comb begin
    p_rnd = (pz_c + 34'sd32768) >>> 16;
    r_rnd = (rz_c + 34'sd32768) >>> 16;
    if (p_rnd < -34'sd9000) begin
      p_clp = -34'sd9000;
    end else if (p_rnd > 34'sd9000) begin
      p_clp = 34'sd9000;
    end else begin
      p_clp = p_rnd;
    end
    // atan2(0, 0) reads as level
    if (rzero_c) begin
      r_clp = '0;
    end else if (r_rnd < -34'sd18000) begin
      r_clp = -34'sd18000;
    end else if (r_rnd > 34'sd18000) begin
      r_clp = 34'sd18000;
    end else begin
      r_clp = r_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= pc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_d  <= zero_c;
      pitch_d <= 16'(p_clp) - 16'(zero_pitch);
      roll_d  <= 16'(r_clp) - 16'(zero_roll);
    end
  end

  // ---- stage E: fold angles into [-90, 90) degrees
  logic               ve, zero_e, m90p_e, m90r_e;
  logic signed [15:0] pitch_e, roll_e, ap_e, ar_e;
  logic signed [15:0] ap_n, ar_n;

  function automatic logic signed [15:0] fold(input logic signed [15:0] a);
    logic signed [15:0] r;
    if (a >= 16'sd27000) begin
      r = a - 16'sd18000 - 16'sd18000;
    end else if (a >= 16'sd9000) begin
      r = a - 16'sd18000;
    end else if (a < -16'sd9000) begin
      r = a + 16'sd18000;
    end else begin
      r = a;
    end
    return r;
  endfunction

  assign ap_n = fold(pitch_d);
  assign ar_n = fold(roll_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (adv) begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_e  <= zero_d;
      pitch_e <= pitch_d;
      roll_e  <= roll_d;
      ap_e    <= ap_n;
      ar_e    <= ar_n;
      m90p_e  <= ap_n == -16'sd9000;
      m90r_e  <= ar_n == -16'sd9000;
    end
  end

  // ---- rotation CORDIC for sine and cosine
  logic                 tp_v, tr_v;
  logic [33:0]          side_tp, side_tpo;
  logic                 m90r_t;
  logic signed [CW-1:0] tpx, tpy, trx, try_;

  assign side_tp = {zero_e, pitch_e, roll_e, m90p_e};

  tch_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .SW(34)) u_pitch_rot (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (ve),
    .side_in  (side_tp),
    .x_in     (34'sd1073741824),
    .y_in     ('0),
    .z_in     (CW'(ap_e) <<< 16),
    .vout     (tp_v),
    .side_out (side_tpo),
    .x_out    (tpx),
    .y_out    (tpy),
    .z_out    ()
  );

  tch_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .SW(1)) u_roll_rot (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (ve),
    .side_in  (m90r_e),
    .x_in     (34'sd1073741824),
    .y_in     ('0),
    .z_in     (CW'(ar_e) <<< 16),
    .vout     (tr_v),
    .side_out (m90r_t),
    .x_out    (trx),
    .y_out    (try_),
    .z_out    ()
  );

  // ---- tangent division
  logic               dp_v, dr_v;
  logic signed [32:0] tanp_q, tanr_q;
  logic [33:0]        side_dp;
  logic               m90r_dv;

  tch_div #(.SW(34)) u_pitch_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (tp_v),
    .num_y    (tpy),
    .den_x    (tpx),
    .side_in  (side_tpo),
    .vout     (dp_v),
    .quot     (tanp_q),
    .side_out (side_dp)
  );

  tch_div #(.SW(1)) u_roll_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (tr_v),
    .num_y    (try_),
    .den_x    (trx),
    .side_in  (m90r_t),
    .vout     (dr_v),
    .quot     (tanr_q),
    .side_out (m90r_dv)
  );

  // ---- stage G: corner distance times tangent
  logic               zero_dv, m90p_dv;
  logic signed [15:0] pitch_dv, roll_dv;
  logic signed [32:0] tp, tr;
  logic signed [21:0] hw, ht, ox, oy, dxf, dxr, dyl, dyr;
  logic               vg, zero_g;
  logic signed [15:0] pitch_g, roll_g;
  logic signed [54:0] pf_g, pr_g, rl_g, rr_g;

  assign {zero_dv, pitch_dv, roll_dv, m90p_dv} = side_dp;
  assign tp  = m90p_dv ? -TAN_CAP : tanp_q;
  assign tr  = m90r_dv ? -TAN_CAP : tanr_q;
  assign hw  = 22'(wheelbase) * 22'sd50;
  assign ht  = 22'(track) * 22'sd50;
  assign ox  = 22'(offset_x) * 22'sd100;
  assign oy  = 22'(offset_y) * 22'sd100;
  assign dxf = hw - ox;
  assign dxr = -hw - ox;
  assign dyl = -ht - oy;
  assign dyr = ht - oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= dp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_g  <= zero_dv;
      pitch_g <= pitch_dv;
      roll_g  <= roll_dv;
      pf_g    <= 55'(dxf) * 55'(tp);
      pr_g    <= 55'(dxr) * 55'(tp);
      rl_g    <= 55'(dyl) * 55'(tr);
      rr_g    <= 55'(dyr) * 55'(tr);
    end
  end

  // ---- stage H: output register
  function automatic logic signed [21:0] corner(input logic signed [54:0] a,
                                                input logic signed [54:0] b);
    logic signed [56:0] s;
    logic signed [56:0] h;
    logic signed [21:0] r;
    s = 57'(a) + 57'(b) + 57'sd32768;
    h = s >>> 16;
    if (h > 57'sd2000000) begin
      r = 22'sd2000000;
    end else if (h < -57'sd2000000) begin
      r = -22'sd2000000;
    end else begin
      r = 22'(h);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status <= zero_g;
      if (zero_g) begin
        pitch_cdeg         <= '0;
        roll_cdeg          <= '0;
        front_left_height  <= '0;
        front_right_height <= '0;
        rear_left_height   <= '0;
        rear_right_height  <= '0;
      end else begin
        pitch_cdeg         <= pitch_g;
        roll_cdeg          <= roll_g;
        front_left_height  <= corner(pf_g, rl_g);
        front_right_height <= corner(pf_g, rr_g);
        rear_left_height   <= corner(pr_g, rl_g);
        rear_right_height  <= corner(pr_g, rr_g);
      end
    end
  end

  `TCH_ASSERT_IMP(a_vec_align, clk, rst, 1'b1, rc_v == pc_v)
  `TCH_ASSERT_IMP(a_div_align, clk, rst, 1'b1, dr_v == dp_v && tr_v == tp_v)
  `TCH_ASSERT_IMP(a_zero_out, clk, rst, out_valid && status, pitch_cdeg == 16'sd0 && front_left_height == 22'sd0)
  `TCH_ASSERT_IMP(a_height_rng, clk, rst, out_valid, rear_right_height <= 22'sd2000000 && rear_right_height >= -22'sd2000000)
  `TCH_ASSERT_NXT(a_freeze, clk, rst, !in_ready, $stable(vg) && $stable(pitch_g))

endmodule
